// ----- hdl/tkdhc_pkg.sv -----
// Shared types and constants for the three-key debounce and hold classifier.
package tkdhc_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;
    localparam int CFG_ADDR_WIDTH     = 5;
    localparam int CFG_DATA_WIDTH     = 32;
    localparam int NOW_WIDTH          = 32;
    localparam int NUM_KEYS           = 3;
    localparam int IN_TDATA_WIDTH     = 40;
    localparam int OUT_TDATA_WIDTH    = 8;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_A_RESTART = 3'd1,
        EV_B_LONG    = 3'd2,
        EV_B_MID     = 3'd3,
        EV_C_LONG    = 3'd4,
        EV_C_TAP     = 3'd5
    } event_code_t;

    typedef enum logic [2:0] {
        REG_LOW_PRESSED   = 3'd0,
        REG_DEBOUNCE_TIME = 3'd1,
        REG_RESTART_HOLD  = 3'd2,
        REG_B_LONG_TIME   = 3'd3,
        REG_B_MID_TIME    = 3'd4,
        REG_C_LONG_TIME   = 3'd5,
        REG_C_TAP_MAX     = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        REL_NONE     = 2'd0,
        REL_AT_LEAST = 2'd1,
        REL_BELOW    = 2'd2
    } rel_mode_t;

    typedef struct packed {
        logic        low_pressed;
        logic [15:0] debounce_time;
        logic [15:0] restart_hold_time;
        logic [15:0] key_b_long_time;
        logic [15:0] key_b_mid_time;
        logic [15:0] key_c_long_time;
        logic [15:0] key_c_tap_max;
    } cfg_t;

    typedef struct packed {
        logic [15:0] long_time;
        logic [15:0] rel_time;
    } key_thr_t;

endpackage

// ----- hdl/three_key_debounce_hold_classifier.sv -----
// Top level: poll input register, three key units, event priority and result register.
//
//   Channel   Direction  Handshake                 Word contents
//   s_axis    in         s_axis_tvalid/tready      [31:0] now_ms, [32] key A, [33] key B,
//                                                  [34] key C level
//   m_axis    out        m_axis_tvalid/tready      [2:0] event_code
//   APB       in/out     psel, penable, pready     seven registers at byte address 4*i
//
// One poll word is accepted every cycle unless a poll waits behind a stalled result; the
// input register is loaded first, then the result register, which offers the event word.
// The per-key state updates in the cycle the poll moves from the input register to the
// result register, so consecutive polls see each other's state with no gap.
// A stalled result holds the result register, and the input register still takes one word.
// Reset is asynchronous and active low; it loads the register defaults and clears key state.
module three_key_debounce_hold_classifier
    import tkdhc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,   // now_ms, key_a, key_b, key_c levels
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,   // event_code, then zero fill
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0]  paddr,
    input  logic [CFG_DATA_WIDTH-1:0]  pwdata,
    output logic [CFG_DATA_WIDTH-1:0]  prdata,
    output logic                       pready
);

    cfg_t                  cfg;
    logic                  in_valid_reg;
    logic [NOW_WIDTH-1:0]  in_now_reg;
    logic [NUM_KEYS-1:0]   in_lvl_reg;
    logic                  out_valid_reg;
    event_code_t           out_code_reg;
    event_code_t           code_next;
    logic                  out_free;
    logic                  step;
    logic                  in_take;
    logic [TIME_WIDTH-1:0] now;
    event_code_t           evt_a, evt_b, evt_c;
    key_thr_t              thr_a, thr_b, thr_c;

    tkdhc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign now           = TIME_WIDTH'(in_now_reg);

    assign thr_a = '{long_time: cfg.restart_hold_time, rel_time: 16'd0};
    assign thr_b = '{long_time: cfg.key_b_long_time,   rel_time: cfg.key_b_mid_time};
    assign thr_c = '{long_time: cfg.key_c_long_time,   rel_time: cfg.key_c_tap_max};

    tkdhc_key #(
        .TIME_WIDTH (TIME_WIDTH),
        .LONG_CODE  (EV_A_RESTART),
        .REL_MODE   (REL_NONE),
        .REL_CODE   (EV_NONE)
    ) u_key_a (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .hold_en       (1'b1),
        .now           (now),
        .level         (in_lvl_reg[0]),
        .low_pressed   (cfg.low_pressed),
        .debounce_time (cfg.debounce_time),
        .thr           (thr_a),
        .evt           (evt_a)
    );

    tkdhc_key #(
        .TIME_WIDTH (TIME_WIDTH),
        .LONG_CODE  (EV_B_LONG),
        .REL_MODE   (REL_AT_LEAST),
        .REL_CODE   (EV_B_MID)
    ) u_key_b (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .hold_en       (evt_a == EV_NONE),
        .now           (now),
        .level         (in_lvl_reg[1]),
        .low_pressed   (cfg.low_pressed),
        .debounce_time (cfg.debounce_time),
        .thr           (thr_b),
        .evt           (evt_b)
    );

    tkdhc_key #(
        .TIME_WIDTH (TIME_WIDTH),
        .LONG_CODE  (EV_C_LONG),
        .REL_MODE   (REL_BELOW),
        .REL_CODE   (EV_C_TAP)
    ) u_key_c (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .hold_en       ((evt_a == EV_NONE) && (evt_b == EV_NONE)),
        .now           (now),
        .level         (in_lvl_reg[2]),
        .low_pressed   (cfg.low_pressed),
        .debounce_time (cfg.debounce_time),
        .thr           (thr_c),
        .evt           (evt_c)
    );

    always_comb
    begin
        if (evt_a != EV_NONE)
            code_next = evt_a;
        else if (evt_b != EV_NONE)
            code_next = evt_b;
        else
            code_next = evt_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_now_reg <= s_axis_tdata[NOW_WIDTH-1:0];
            in_lvl_reg <= s_axis_tdata[NOW_WIDTH +: NUM_KEYS];
        end
        if (step)
            out_code_reg <= code_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_WIDTH'(out_code_reg);

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("poll left the input register without producing a result");

    a_blocked_poll_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_now_reg)
                                         && $stable(in_lvl_reg)))
        else $error("waiting poll was lost or changed");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_code_reg <= EV_C_TAP))
        else $error("event code out of range");

endmodule

// ----- hdl/tkdhc_cfg.sv -----
// Configuration register file with its APB-style access port.
module tkdhc_cfg
    import tkdhc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [CFG_DATA_WIDTH-1:0] pwdata,
    output logic [CFG_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_index_t'(paddr[CFG_ADDR_WIDTH-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_pressed       <= 1'b1;
            cfg_reg.debounce_time     <= 16'd50;
            cfg_reg.restart_hold_time <= 16'd3000;
            cfg_reg.key_b_long_time   <= 16'd5000;
            cfg_reg.key_b_mid_time    <= 16'd2000;
            cfg_reg.key_c_long_time   <= 16'd1500;
            cfg_reg.key_c_tap_max     <= 16'd1000;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LOW_PRESSED:   cfg_reg.low_pressed       <= pwdata[0];
                REG_DEBOUNCE_TIME: cfg_reg.debounce_time     <= pwdata[15:0];
                REG_RESTART_HOLD:  cfg_reg.restart_hold_time <= pwdata[15:0];
                REG_B_LONG_TIME:   cfg_reg.key_b_long_time   <= pwdata[15:0];
                REG_B_MID_TIME:    cfg_reg.key_b_mid_time    <= pwdata[15:0];
                REG_C_LONG_TIME:   cfg_reg.key_c_long_time   <= pwdata[15:0];
                REG_C_TAP_MAX:     cfg_reg.key_c_tap_max     <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_LOW_PRESSED:   prdata = CFG_DATA_WIDTH'(cfg_reg.low_pressed);
            REG_DEBOUNCE_TIME: prdata = CFG_DATA_WIDTH'(cfg_reg.debounce_time);
            REG_RESTART_HOLD:  prdata = CFG_DATA_WIDTH'(cfg_reg.restart_hold_time);
            REG_B_LONG_TIME:   prdata = CFG_DATA_WIDTH'(cfg_reg.key_b_long_time);
            REG_B_MID_TIME:    prdata = CFG_DATA_WIDTH'(cfg_reg.key_b_mid_time);
            REG_C_LONG_TIME:   prdata = CFG_DATA_WIDTH'(cfg_reg.key_c_long_time);
            REG_C_TAP_MAX:     prdata = CFG_DATA_WIDTH'(cfg_reg.key_c_tap_max);
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- hdl/tkdhc_key.sv -----
// One key: debounce filter, hold tracking and event classification.
module tkdhc_key
    import tkdhc_pkg::*;
#(
    parameter int          TIME_WIDTH = TIME_WIDTH_DEFAULT,
    parameter event_code_t LONG_CODE  = EV_A_RESTART,
    parameter rel_mode_t   REL_MODE   = REL_NONE,
    parameter event_code_t REL_CODE   = EV_NONE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  hold_en,
    input  logic [TIME_WIDTH-1:0] now,
    input  logic                  level,
    input  logic                  low_pressed,
    input  logic [15:0]           debounce_time,
    input  key_thr_t              thr,
    output event_code_t           evt
);

    logic                  last_raw_reg,  last_raw_next;
    logic [TIME_WIDTH-1:0] change_reg,    change_next;
    logic                  stable_reg,    stable_next;
    logic                  held_reg,      held_next;
    logic [TIME_WIDTH-1:0] start_reg,     start_next;
    logic                  fired_reg,     fired_next;

    logic                  raw;
    logic [TIME_WIDTH-1:0] since_change;
    logic [TIME_WIDTH-1:0] held_time;
    logic                  pressed;

    // A raw level of one means pressed after the polarity is applied.
    assign raw = level ^ low_pressed;

    always_comb
    begin
        last_raw_next = raw;
        change_next   = (raw != last_raw_reg) ? now : change_reg;
        since_change  = now - change_next;
        stable_next   = (since_change >= TIME_WIDTH'(debounce_time)) ? raw : stable_reg;
        pressed       = stable_next;
    end

    always_comb
    begin
        held_next  = held_reg;
        start_next = start_reg;
        fired_next = fired_reg;
        evt        = EV_NONE;
        held_time  = now - start_reg;
        if (pressed && !held_reg)
        begin
            held_next  = 1'b1;
            start_next = now;
            fired_next = 1'b0;
        end
        else if (pressed && !fired_reg && held_time >= TIME_WIDTH'(thr.long_time))
        begin
            fired_next = 1'b1;
            evt        = LONG_CODE;
        end
        else if (!pressed && held_reg)
        begin
            held_next = 1'b0;
            if (!fired_reg)
            begin
                case (REL_MODE)
                    REL_AT_LEAST:
                        if (held_time >= TIME_WIDTH'(thr.rel_time))
                            evt = REL_CODE;
                    REL_BELOW:
                        if (held_time < TIME_WIDTH'(thr.rel_time))
                            evt = REL_CODE;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= 1'b0;
            change_reg   <= '0;
            stable_reg   <= 1'b0;
            held_reg     <= 1'b0;
            start_reg    <= '0;
            fired_reg    <= 1'b0;
        end
        else if (step)
        begin
            last_raw_reg <= last_raw_next;
            change_reg   <= change_next;
            stable_reg   <= stable_next;
            // An event on an earlier key freezes this key's hold state.
            if (hold_en)
            begin
                held_reg  <= held_next;
                start_reg <= start_next;
                fired_reg <= fired_next;
            end
        end
    end

endmodule
